FILE: hw/rtl/llws_pkg.sv
// Link-loss watchdog supervisor: shared types and constants.
// No dependencies; used by every module of the block.
package llws_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned IVL_W   = 16;
  localparam int unsigned FAIL_W  = 8;
  localparam int unsigned CODE_W  = 4;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned CFG_W   = 16;

  localparam logic [CODE_W-1:0]  CODE_NONE      = 4'd0;
  localparam logic [CODE_W-1:0]  CODE_LINK_DOWN = 4'd1;
  localparam logic [FAIL_W-1:0]  FAIL_SAT       = 8'd255;
  localparam logic [COUNT_W-1:0] COUNT_SAT      = 16'd65535;

  localparam logic [IVL_W-1:0]  CHECK_IVL_RST = 16'd1000;
  localparam logic [FAIL_W-1:0] THRESH_RST    = 8'd3;
  localparam logic [IVL_W-1:0]  HEALTHY_RST   = 16'd1000;
  localparam logic [IVL_W-1:0]  DEGRADED_RST  = 16'd2000;

  typedef enum logic [1:0] {
    OP_POLL   = 2'd0,
    OP_REPORT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_RESET  = 2'd3
  } llws_op_t;

  typedef enum logic [1:0] {
    CFG_CHECK_INTERVAL = 2'd0,
    CFG_FAIL_THRESHOLD = 2'd1,
    CFG_HEALTHY_FEED   = 2'd2,
    CFG_DEGRADED_FEED  = 2'd3
  } llws_cfg_idx_t;

  typedef struct packed {
    logic [IVL_W-1:0]  check_interval_ms;
    logic [FAIL_W-1:0] fail_threshold;
    logic [IVL_W-1:0]  healthy_feed_ms;
    logic [IVL_W-1:0]  degraded_feed_ms;
  } llws_cfg_t;

  typedef struct packed {
    llws_op_t          opcode;
    logic [TIME_W-1:0] now_ms;
    logic              link_up;
    logic              client_running;
    logic [CODE_W-1:0] reported_type;
  } llws_in_t;

  typedef struct packed {
    logic               watchdog_kick;
    logic               notify_recovery;
    logic [CODE_W-1:0]  active_type;
    logic [COUNT_W-1:0] repeat_count;
    logic [TIME_W-1:0]  event_time;
    logic [FAIL_W-1:0]  link_fail_count;
  } llws_out_t;

endpackage

FILE: hw/rtl/llws_cfg_regs.sv
// Configuration register file: check interval, fail threshold, feed intervals.
// Depends on llws_pkg.
module llws_cfg_regs (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  llws_pkg::llws_cfg_idx_t cfg_index,
  input  logic [llws_pkg::CFG_W-1:0] cfg_wdata,
  output llws_pkg::llws_cfg_t    cfg
);
  import llws_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.check_interval_ms <= CHECK_IVL_RST;
      cfg.fail_threshold    <= THRESH_RST;
      cfg.healthy_feed_ms   <= HEALTHY_RST;
      cfg.degraded_feed_ms  <= DEGRADED_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_CHECK_INTERVAL: cfg.check_interval_ms <= cfg_wdata;
        CFG_FAIL_THRESHOLD: cfg.fail_threshold    <= cfg_wdata[FAIL_W-1:0];
        CFG_HEALTHY_FEED:   cfg.healthy_feed_ms   <= cfg_wdata;
        CFG_DEGRADED_FEED:  cfg.degraded_feed_ms  <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/llws_core.sv
// Supervisor state and its single-pass update for one transaction.
// Depends on llws_pkg.
module llws_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  llws_pkg::llws_cfg_t cfg,
  input  llws_pkg::llws_in_t  item,
  output llws_pkg::llws_out_t res
);
  import llws_pkg::*;

  logic [TIME_W-1:0]  last_check_time, last_check_time_next;
  logic [TIME_W-1:0]  last_kick_time, last_kick_time_next;
  logic [FAIL_W-1:0]  fail_counter, fail_counter_next;
  logic [CODE_W-1:0]  recorded_code, recorded_code_next;
  logic [COUNT_W-1:0] report_count, report_count_next;
  logic [TIME_W-1:0]  report_time, report_time_next;

  logic [TIME_W-1:0] since_check, since_kick;
  logic [FAIL_W-1:0] fail_inc;
  logic [IVL_W-1:0]  feed_ivl;
  logic              check_due, kick, notify;

  assign since_check = item.now_ms - last_check_time;
  assign since_kick  = item.now_ms - last_kick_time;
  assign check_due   = since_check >= {{(TIME_W-IVL_W){1'b0}}, cfg.check_interval_ms};
  assign fail_inc    = (fail_counter < FAIL_SAT) ? fail_counter + 1'b1 : fail_counter;

  always_comb begin
    last_check_time_next = last_check_time;
    last_kick_time_next  = last_kick_time;
    fail_counter_next    = fail_counter;
    recorded_code_next   = recorded_code;
    report_count_next    = report_count;
    report_time_next     = report_time;
    kick                 = 1'b0;
    notify               = 1'b0;
    feed_ivl             = cfg.degraded_feed_ms;
    case (item.opcode)
      OP_POLL: begin
        if (check_due) begin
          last_check_time_next = item.now_ms;
          if (!item.link_up) begin
            fail_counter_next = fail_inc;
            // link-down is recorded as a fresh exception; never a repeat here
            if (fail_inc >= cfg.fail_threshold && recorded_code != CODE_LINK_DOWN) begin
              notify             = 1'b1;
              recorded_code_next = CODE_LINK_DOWN;
              report_count_next  = {{(COUNT_W-1){1'b0}}, 1'b1};
              report_time_next   = item.now_ms;
            end
          end else begin
            fail_counter_next = '0;
          end
          feed_ivl = (item.client_running && recorded_code_next == CODE_NONE) ?
                     cfg.healthy_feed_ms : cfg.degraded_feed_ms;
          if (since_kick >= {{(TIME_W-IVL_W){1'b0}}, feed_ivl}) begin
            kick                = 1'b1;
            last_kick_time_next = item.now_ms;
          end
        end
      end
      OP_REPORT: begin
        if (item.reported_type != CODE_NONE) begin
          report_time_next = item.now_ms;
          if (recorded_code == item.reported_type) begin
            if (report_count < COUNT_SAT) report_count_next = report_count + 1'b1;
          end else begin
            recorded_code_next = item.reported_type;
            report_count_next  = {{(COUNT_W-1){1'b0}}, 1'b1};
          end
        end
      end
      OP_CLEAR: begin
        recorded_code_next = CODE_NONE;
        report_count_next  = '0;
        report_time_next   = '0;
      end
      OP_RESET: begin
        recorded_code_next  = CODE_NONE;
        report_count_next   = '0;
        report_time_next    = '0;
        fail_counter_next   = '0;
        last_kick_time_next = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_check_time <= '0;
      last_kick_time  <= '0;
      fail_counter    <= '0;
      recorded_code   <= CODE_NONE;
      report_count    <= '0;
      report_time     <= '0;
    end else if (fire) begin
      last_check_time <= last_check_time_next;
      last_kick_time  <= last_kick_time_next;
      fail_counter    <= fail_counter_next;
      recorded_code   <= recorded_code_next;
      report_count    <= report_count_next;
      report_time     <= report_time_next;
    end
  end

  always_comb begin
    res.watchdog_kick   = kick;
    res.notify_recovery = notify;
    res.active_type     = recorded_code_next;
    res.repeat_count    = report_count_next;
    res.event_time      = report_time_next;
    res.link_fail_count = fail_counter_next;
  end

endmodule

FILE: hw/rtl/link_loss_watchdog_supervisor.sv
// Top level of the link-loss watchdog supervisor: input register, core, output register.
// Depends on llws_pkg, llws_cfg_regs and llws_core.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------
//  in      | in        | in_valid / in_stall  | in_data  (llws_in_t)
//  out     | out       | out_valid / out_stall| out_data (llws_out_t)
//  cfg     | in        | cfg_wr_en            | cfg_index, cfg_wdata
//
// One transaction per cycle sustained while out_stall is low; an accepted transaction
// passes through the input register and then the result register.
// The supervisor state update is one short compare/increment pass in llws_core.
// rst is synchronous: it clears the state, restores config defaults, empties both stages.
// out_stall holds the result register; in_stall rises only while the input
// register holds a transaction that cannot move on.
module link_loss_watchdog_supervisor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  llws_pkg::llws_in_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output llws_pkg::llws_out_t         out_data,
  input  logic                        cfg_wr_en,
  input  llws_pkg::llws_cfg_idx_t     cfg_index,
  input  logic [llws_pkg::CFG_W-1:0]  cfg_wdata
);
  import llws_pkg::*;

  llws_cfg_t cfg;
  llws_in_t  item;
  llws_out_t res;
  logic      item_valid;
  logic      out_free;   // result register can take a new transaction
  logic      fire;       // input register drains into the core this cycle
  logic      take;       // new transaction accepted on the in channel

  assign out_free = !out_valid || !out_stall;
  assign fire     = item_valid && out_free;
  assign in_stall = item_valid && !out_free;
  assign take     = in_valid && !in_stall;

  llws_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (take) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item <= in_data;
    end
  end

  // State update happens only when the result has somewhere to go
  llws_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .cfg  (cfg),
    .item (item),
    .res  (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= res;
    end
  end

  // Checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> item_valid)
    else $error("in_stall raised with an empty input register");

  a_fire_loads_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("processed transaction did not reach the result register");

  a_notify_records_link_down: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.notify_recovery) |->
      (out_data.active_type == CODE_LINK_DOWN && out_data.link_fail_count != '0))
    else $error("notify without a recorded link-down");

  a_no_code_no_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.active_type == CODE_NONE) |-> (out_data.repeat_count == '0))
    else $error("repeat count set with no exception recorded");

endmodule
